// File: design/lbpe_pkg.sv
// ----------------------------------------------------------------------------
// lbpe_pkg
// Shared types and constants of the LED blink pattern engine.
// ----------------------------------------------------------------------------
package lbpe_pkg;

   typedef enum logic [2:0] {
      PAT_OFF       = 3'd0,
      PAT_ON        = 3'd1,
      PAT_SLOW      = 3'd2,
      PAT_FAST      = 3'd3,
      PAT_RAPID     = 3'd4,
      PAT_ERROR     = 3'd5,
      PAT_HEARTBEAT = 3'd6
   } pattern_type;

   localparam int NUM_PATTERN_REGS = 6;
   localparam int OUT_BITS         = 6;

   localparam logic [2:0] REG_DRIVE_ENABLE = 3'd6;

   localparam logic [31:0] SLOW_PERIOD  = 32'd1000;
   localparam logic [31:0] FAST_PERIOD  = 32'd250;
   localparam logic [31:0] RAPID_PERIOD = 32'd100;
   localparam logic [31:0] ERROR_STEP   = 32'd100;
   localparam logic [31:0] HEART_STEP   = 32'd150;
   localparam logic [31:0] PAUSE_PERIOD = 32'd1000;

   localparam logic [2:0] ERROR_LIMIT = 3'd6;
   localparam logic [2:0] HEART_LIMIT = 3'd4;

   typedef struct packed {
      logic        update;
      logic        clear_count;
      pattern_type pattern;
   } led_ctrl_type;

endpackage

// File: design/lbpe_led.sv
// ----------------------------------------------------------------------------
// lbpe_led
// State and next-level logic of one LED: level, last toggle time and
// flash counter, advanced once per update.
// ----------------------------------------------------------------------------
module lbpe_led (
   input  logic                  clock,
   input  logic                  reset,
   input  lbpe_pkg::led_ctrl_type ctrl,
   input  logic [31:0]           now_ms,
   output logic                  level_next,
   output logic                  changed
);
   import lbpe_pkg::*;

   logic        level_ff;
   logic [31:0] last_ff;
   logic [2:0]  count_ff;
   logic [2:0]  count_in;
   logic [31:0] elapsed;
   logic        toggle;
   logic        level_in;

   assign elapsed = now_ms - last_ff;

   always_comb begin
      toggle   = 1'b0;
      level_in = level_ff;
      count_in = count_ff;
      unique case (ctrl.pattern)
         PAT_OFF:   level_in = 1'b0;
         PAT_ON:    level_in = 1'b1;
         PAT_SLOW:  toggle = (elapsed >= SLOW_PERIOD);
         PAT_FAST:  toggle = (elapsed >= FAST_PERIOD);
         PAT_RAPID: toggle = (elapsed >= RAPID_PERIOD);
         PAT_ERROR: begin
            if (count_ff < ERROR_LIMIT) begin
               toggle = (elapsed >= ERROR_STEP);
               if (toggle) count_in = count_ff + 3'd1;
            end else begin
               toggle = (elapsed >= PAUSE_PERIOD);
               if (toggle) count_in = 3'd0;
            end
         end
         PAT_HEARTBEAT: begin
            if (count_ff < HEART_LIMIT) begin
               toggle = (elapsed >= HEART_STEP);
               if (toggle) count_in = count_ff + 3'd1;
            end else begin
               toggle = (elapsed >= PAUSE_PERIOD);
               if (toggle) count_in = 3'd0;
            end
         end
         default: level_in = level_ff;
      endcase
      if (toggle) level_in = ~level_ff;
   end

   assign level_next = ctrl.update ? level_in : level_ff;
   assign changed    = ctrl.update && (level_in != level_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= 1'b0;
         last_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (ctrl.clear_count) begin
            count_ff <= '0;
         end else if (ctrl.update) begin
            count_ff <= count_in;
         end
         if (ctrl.update) begin
            level_ff <= level_in;
            if (toggle) last_ff <= now_ms;
         end
      end
   end

endmodule

// File: design/led_blink_pattern_engine.sv
// ----------------------------------------------------------------------------
// led_blink_pattern_engine
// Six-channel LED blink pattern generator driven by millisecond updates.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one transfer per update, req_tdata = now_ms (bits 31:0).
//   rsp_*  : one transfer per update, rsp_tdata = led_levels (5:0),
//            changed_mask (11:6), zero padding (15:12).
//   csr_*  : register writes, index 0..5 pattern of LED 0..5, index 6
//            drive_enable; other indexes are ignored. csr_ready is always
//            high. A pattern write clears that LED's flash counter.
// Timing:
//   an update waits in the input register and is evaluated into the
//   result register once that is empty or being taken. One update per
//   cycle is sustained while rsp_tready stays high; the clock is set by
//   the single 32-bit subtract and compare per LED between the two registers.
// Reset zeroes all LEDs, times, counters, patterns, enable and valid flags.
// When the receiver stalls, the result is held, one more update waits in
// the input register, and req_tready then drops until rsp_tready returns.
// ----------------------------------------------------------------------------
module led_blink_pattern_engine #(
   parameter int NUM_LEDS = 6
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // now_ms
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // led_levels, changed_mask, zero pad
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [2:0]  csr_data
);
   import lbpe_pkg::*;

   pattern_type         pattern_ff [NUM_PATTERN_REGS];
   logic                enable_ff;
   logic                in_valid_ff;
   logic [31:0]         in_now_ff;
   logic                rsp_valid_ff;
   logic [OUT_BITS-1:0] levels_ff;
   logic [OUT_BITS-1:0] changed_ff;
   logic                advance;
   logic                csr_write;
   logic [NUM_LEDS-1:0] level_vec;
   logic [NUM_LEDS-1:0] changed_vec;
   logic [OUT_BITS-1:0] levels_in;
   logic [OUT_BITS-1:0] changed_in;

   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < NUM_PATTERN_REGS; p++) pattern_ff[p] <= PAT_OFF;
         enable_ff <= 1'b0;
      end else if (csr_write) begin
         for (int p = 0; p < NUM_PATTERN_REGS; p++) begin
            if (csr_index == 3'(p)) pattern_ff[p] <= pattern_type'(csr_data);
         end
         if (csr_index == REG_DRIVE_ENABLE) enable_ff <= csr_data[0];
      end
   end

   for (genvar i = 0; i < NUM_LEDS; i++) begin : g_led
      led_ctrl_type ctrl;
      if (i < NUM_PATTERN_REGS) begin : g_reg
         assign ctrl.pattern     = pattern_ff[i];
         assign ctrl.clear_count = csr_write && (csr_index == 3'(i));
      end else begin : g_noreg
         assign ctrl.pattern     = PAT_OFF;
         assign ctrl.clear_count = 1'b0;
      end
      assign ctrl.update = advance && enable_ff;

      lbpe_led u_led (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .now_ms     (in_now_ff),
         .level_next (level_vec[i]),
         .changed    (changed_vec[i])
      );
   end

   for (genvar b = 0; b < OUT_BITS; b++) begin : g_out
      if (b < NUM_LEDS) begin : g_used
         assign levels_in[b]  = level_vec[b];
         assign changed_in[b] = changed_vec[b];
      end else begin : g_pad
         assign levels_in[b]  = 1'b0;
         assign changed_in[b] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) in_valid_ff <= req_tvalid;
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) in_now_ff <= req_tdata;
      if (advance) begin
         levels_ff  <= levels_in;
         changed_ff <= changed_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, changed_ff, levels_ff};

   a_disabled_no_change: assert property (@(posedge clock) disable iff (reset)
      (advance && !enable_ff) |=> (rsp_tdata[11:6] == 6'd0))
      else $error("change reported while disabled");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && rsp_valid_ff && !rsp_tready))
      else $error("input stalled without a full pipeline");

   a_held_update_kept: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_now_ff)))
      else $error("waiting update lost or changed");

   a_disabled_levels_held: assert property (@(posedge clock) disable iff (reset)
      (advance && !enable_ff && rsp_valid_ff) |=>
      (rsp_tdata[5:0] == $past(levels_ff)))
      else $error("levels moved while disabled");

endmodule

// File: tb/led_blink_pattern_engine_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_blink_pattern_engine_test
// Self-checking bench for the LED blink pattern engine. A short scripted run
// walks every pattern code, the flash and heartbeat sequences, time wrap and
// the disabled state. Random phases follow, each with new register writes and
// one of four idle and stall mixes. Typed script rows are checked against
// their table values, all others against a behavioral model of the six LEDs.
// ----------------------------------------------------------------------------
module led_blink_pattern_engine_test;
   import lbpe_pkg::*;

   localparam int LED_COUNT     = 6;
   localparam int PHASES        = 13;
   localparam int PHASE_UPDATES = 100;
   localparam int HOLD_CYCLES   = 60;
   localparam int SCRIPT_ROWS   = 33;

   localparam logic [2:0] PAT_HOLD   = 3'd7;
   localparam logic [2:0] REG_UNUSED = 3'd7;

   localparam logic [2:0] REG_PATTERN_POWER       = 3'd0;
   localparam logic [2:0] REG_PATTERN_LINK        = 3'd1;
   localparam logic [2:0] REG_PATTERN_FIX         = 3'd2;
   localparam logic [2:0] REG_PATTERN_PRECISE_FIX = 3'd3;
   localparam logic [2:0] REG_PATTERN_STANDBY     = 3'd4;
   localparam logic [2:0] REG_PATTERN_ACTIVE      = 3'd5;

   localparam logic ROW_UPDATE = 1'b0;
   localparam logic ROW_WRITE  = 1'b1;

   typedef struct packed {
      logic [5:0] changed;
      logic [5:0] levels;
   } led_result;

   typedef struct packed {
      logic        kind;
      logic [2:0]  index;
      logic [2:0]  value;
      logic [31:0] now;
      logic        typed;
      logic [5:0]  levels;
      logic [5:0]  changed;
   } script_row;

   localparam script_row SCRIPT [SCRIPT_ROWS] = '{
      // after reset, disabled
      '{ROW_UPDATE, 3'd0, 3'd0, 32'h0000_0000, 1'b1, 6'h00, 6'h00},
      '{ROW_UPDATE, 3'd0, 3'd0, 32'hFFFF_FFFF, 1'b1, 6'h00, 6'h00},
      // one pattern per led, then enable
      '{ROW_WRITE, REG_PATTERN_POWER, PAT_ON, 32'd0, 1'b0, 6'h00, 6'h00},
      '{ROW_WRITE, REG_PATTERN_LINK, PAT_OFF, 32'd0, 1'b0, 6'h00, 6'h00},
      '{ROW_WRITE, REG_PATTERN_FIX, PAT_SLOW, 32'd0, 1'b0, 6'h00, 6'h00},
      '{ROW_WRITE, REG_PATTERN_PRECISE_FIX, PAT_FAST, 32'd0, 1'b0, 6'h00, 6'h00},
      '{ROW_WRITE, REG_PATTERN_STANDBY, PAT_RAPID, 32'd0, 1'b0, 6'h00, 6'h00},
      '{ROW_WRITE, REG_PATTERN_ACTIVE, PAT_ERROR, 32'd0, 1'b0, 6'h00, 6'h00},
      '{ROW_WRITE, REG_DRIVE_ENABLE, 3'd1, 32'd0, 1'b0, 6'h00, 6'h00},
      '{ROW_UPDATE, 3'd0, 3'd0, 32'd99, 1'b1, 6'h01, 6'h01},
      '{ROW_UPDATE, 3'd0, 3'd0, 32'd100, 1'b1, 6'h31, 6'h30},
      // error flash steps, pause, slow period
      '{ROW_UPDATE, 3'd0, 3'd0, 32'd200, 1'b0, 6'h00, 6'h00},
      '{ROW_UPDATE, 3'd0, 3'd0, 32'd250, 1'b0, 6'h00, 6'h00},
      '{ROW_UPDATE, 3'd0, 3'd0, 32'd300, 1'b0, 6'h00, 6'h00},
      '{ROW_UPDATE, 3'd0, 3'd0, 32'd400, 1'b0, 6'h00, 6'h00},
      '{ROW_UPDATE, 3'd0, 3'd0, 32'd500, 1'b0, 6'h00, 6'h00},
      '{ROW_UPDATE, 3'd0, 3'd0, 32'd600, 1'b0, 6'h00, 6'h00},
      '{ROW_UPDATE, 3'd0, 3'd0, 32'd700, 1'b0, 6'h00, 6'h00},
      '{ROW_UPDATE, 3'd0, 3'd0, 32'd1000, 1'b0, 6'h00, 6'h00},
      '{ROW_UPDATE, 3'd0, 3'd0, 32'd1600, 1'b0, 6'h00, 6'h00},
      // unused code holds, heartbeat, write to a missing register
      '{ROW_WRITE, REG_PATTERN_POWER, PAT_HOLD, 32'd0, 1'b0, 6'h00, 6'h00},
      '{ROW_WRITE, REG_PATTERN_LINK, PAT_HEARTBEAT, 32'd0, 1'b0, 6'h00, 6'h00},
      '{ROW_WRITE, REG_UNUSED, 3'd5, 32'd0, 1'b0, 6'h00, 6'h00},
      '{ROW_UPDATE, 3'd0, 3'd0, 32'd1750, 1'b0, 6'h00, 6'h00},
      '{ROW_UPDATE, 3'd0, 3'd0, 32'd1900, 1'b0, 6'h00, 6'h00},
      '{ROW_UPDATE, 3'd0, 3'd0, 32'd2050, 1'b0, 6'h00, 6'h00},
      '{ROW_UPDATE, 3'd0, 3'd0, 32'd2200, 1'b0, 6'h00, 6'h00},
      '{ROW_UPDATE, 3'd0, 3'd0, 32'd3200, 1'b0, 6'h00, 6'h00},
      // time wrap
      '{ROW_UPDATE, 3'd0, 3'd0, 32'hFFFF_FF00, 1'b0, 6'h00, 6'h00},
      '{ROW_UPDATE, 3'd0, 3'd0, 32'h0000_0010, 1'b0, 6'h00, 6'h00},
      // disabled with levels lit
      '{ROW_WRITE, REG_DRIVE_ENABLE, 3'd6, 32'd0, 1'b0, 6'h00, 6'h00},
      '{ROW_UPDATE, 3'd0, 3'd0, 32'h0000_5000, 1'b0, 6'h00, 6'h00},
      '{ROW_UPDATE, 3'd0, 3'd0, 32'h8000_0000, 1'b0, 6'h00, 6'h00}
   };

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;    // now_ms
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;          // led_levels, changed_mask, zero pad
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index  = '0;
   logic [2:0]  csr_data   = '0;

   logic        led_on      [LED_COUNT] = '{default: 1'b0};
   logic [31:0] toggled_at  [LED_COUNT] = '{default: '0};
   logic [2:0]  flash_count [LED_COUNT] = '{default: '0};
   logic [2:0]  pattern_sel [LED_COUNT] = '{default: '0};
   logic        drive_on = 1'b0;

   led_result pending_leds [$];

   int fail_count      = 0;
   int results_checked = 0;
   int updates_sent    = 0;
   int writes_done     = 0;
   int send_idle_pct   = 0;
   int stall_pct       = 0;
   int hold_requests   = 0;
   int hold_served     = 0;
   int hold_left       = 0;

   led_blink_pattern_engine #(.NUM_LEDS(LED_COUNT)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void advance_leds(input logic [31:0] now, output led_result result);
      logic [31:0] elapsed;
      logic [31:0] stride;
      logic [2:0]  limit;
      logic        flip;
      logic        level;
      int          i;
      result = '0;
      for (i = 0; i < LED_COUNT; i++) begin
         if (drive_on) begin
            level   = led_on[i];
            elapsed = now - toggled_at[i];
            flip    = 1'b0;
            case (pattern_sel[i])
               PAT_OFF:   level = 1'b0;
               PAT_ON:    level = 1'b1;
               PAT_SLOW:  flip = (elapsed >= SLOW_PERIOD);
               PAT_FAST:  flip = (elapsed >= FAST_PERIOD);
               PAT_RAPID: flip = (elapsed >= RAPID_PERIOD);
               PAT_ERROR, PAT_HEARTBEAT: begin
                  limit  = (pattern_sel[i] == PAT_ERROR) ? ERROR_LIMIT : HEART_LIMIT;
                  stride = (pattern_sel[i] == PAT_ERROR) ? ERROR_STEP : HEART_STEP;
                  if (flash_count[i] < limit) begin
                     if (elapsed >= stride) begin
                        flip           = 1'b1;
                        flash_count[i] = flash_count[i] + 3'd1;
                     end
                  end else if (elapsed >= PAUSE_PERIOD) begin
                     flip           = 1'b1;
                     flash_count[i] = '0;
                  end
               end
               default: ;
            endcase
            if (flip) begin
               level         = !level;
               toggled_at[i] = now;
            end
            result.changed[i] = (level != led_on[i]);
            led_on[i]         = level;
         end
         result.levels[i] = led_on[i];
      end
   endfunction

   task automatic write_reg(input logic [2:0] index, input logic [2:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (index < NUM_PATTERN_REGS) begin
         pattern_sel[index] = value;
         flash_count[index] = '0;
      end else if (index == REG_DRIVE_ENABLE) begin
         drive_on = value[0];
      end
      writes_done++;
   endtask

   task automatic send_update(input logic [31:0] now, input logic typed,
                              input led_result typed_result);
      led_result predicted;
      csr_valid <= 1'b0;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= now;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      advance_leds(now, predicted);
      pending_leds.push_back(typed ? typed_result : predicted);
      updates_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_leds.size() != 0) @(posedge clock);
   endtask

   task automatic configure_phase(input int phase);
      logic [2:0] code;
      logic       enable;
      int         led;
      enable = !(phase == 3 || phase == 9);
      write_reg(REG_UNUSED, 3'($urandom_range(7)));
      for (led = 0; led < NUM_PATTERN_REGS; led++) begin
         case (phase)
            1:       code = PAT_OFF;
            2:       code = PAT_HOLD;
            5:       code = PAT_HEARTBEAT;
            6:       code = PAT_ERROR;
            default: code = 3'($urandom_range(7));
         endcase
         // later phases keep some registers so flash counts carry over
         if (phase < 8 || $urandom_range(99) < 75) write_reg(3'(led), code);
      end
      write_reg(REG_DRIVE_ENABLE, {2'($urandom_range(3)), enable});
   endtask

   // receiver side: random stalls plus occasional long hold-offs
   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      led_result want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_leds.size() == 0) begin
            $error("result transfer with no update pending: %h", rsp_tdata);
            fail_count++;
         end else begin
            want = pending_leds.pop_front();
            results_checked++;
            if (rsp_tdata[5:0] !== want.levels) begin
               $error("led_levels: expected %h, got %h", want.levels, rsp_tdata[5:0]);
               fail_count++;
            end
            if (rsp_tdata[11:6] !== want.changed) begin
               $error("changed_mask: expected %h, got %h", want.changed, rsp_tdata[11:6]);
               fail_count++;
            end
            if (rsp_tdata[15:12] !== 4'h0) begin
               $error("pad: expected %h, got %h", 4'h0, rsp_tdata[15:12]);
               fail_count++;
            end
         end
      end
   end

   initial begin
      logic [31:0] now;
      int          phase;
      int          n;
      int          pick;
      int          scripted;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int k = 0; k < SCRIPT_ROWS; k++) begin
         if (SCRIPT[k].kind == ROW_WRITE) begin
            wait_drained();
            write_reg(SCRIPT[k].index, SCRIPT[k].value);
         end else begin
            send_update(SCRIPT[k].now, SCRIPT[k].typed,
                        {SCRIPT[k].changed, SCRIPT[k].levels});
         end
      end
      scripted = updates_sent;

      for (phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 61; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 61; end
            default: begin send_idle_pct = 35; stall_pct = 35; end
         endcase
         configure_phase(phase);
         if (phase % 4 == 0) hold_requests++;
         now = (phase % 2 == 0) ? $urandom : 32'hFFFF_FFFF - $urandom_range(3000);
         for (n = 0; n < PHASE_UPDATES; n++) begin
            if (n == PHASE_UPDATES / 2) wait_drained();
            send_update(now, 1'b0, '0);
            pick = $urandom_range(99);
            if (pick < 70) now += $urandom_range(60);
            else if (pick < 90) now += $urandom_range(400, 61);
            else if (pick < 97) now += $urandom_range(1500, 401);
            else now = $urandom;
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      $display("covered %0d scripted and %0d random updates, %0d register writes",
               scripted, updates_sent - scripted, writes_done);
      $display("%0d results checked across %0d register settings", results_checked,
               PHASES + 1);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout with %0d results outstanding", pending_leds.size());
      $display("Some tests failed");
      $finish;
   end

endmodule
